// ===== src/ers_pkg.sv =====
// Shared types and constants for the elliptic row span block.
// Used by elliptic_region_row_span and by its port checker; depends on nothing.
package ers_pkg;

    localparam int MAX_DIM = 4096;

    // Field widths of the input request.
    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int DIM_W   = 13;
    localparam int RIDX_W  = 12;

    // Field widths of the result.
    localparam int SPAN_W  = 12;
    localparam int LEN_W   = 13;
    localparam int ADDR_W  = 24;
    localparam int TOTAL_W = 25;

    // Input tdata layout, lowest field first.
    localparam int IN_COL_LSB  = 0;
    localparam int IN_ROW_LSB  = IN_COL_LSB + COL_W;
    localparam int IN_W_LSB    = IN_ROW_LSB + ROW_W;
    localparam int IN_H_LSB    = IN_W_LSB + DIM_W;
    localparam int IN_RIDX_LSB = IN_H_LSB + DIM_W;
    localparam int IN_BITS     = IN_RIDX_LSB + RIDX_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int OUT_FIRST_LSB = 0;
    localparam int OUT_LAST_LSB  = OUT_FIRST_LSB + SPAN_W;
    localparam int OUT_LEN_LSB   = OUT_LAST_LSB + SPAN_W;
    localparam int OUT_ADDR_LSB  = OUT_LEN_LSB + LEN_W;
    localparam int OUT_OFS_LSB   = OUT_ADDR_LSB + ADDR_W;
    localparam int OUT_AFTER_LSB = OUT_OFS_LSB + TOTAL_W;
    localparam int OUT_BITS      = OUT_AFTER_LSB + TOTAL_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_WIDTH  = 1'b0,
        CFG_FIELD_HEIGHT = 1'b1
    } cfg_reg_t;

    // Iteration counts of the serial units.
    localparam int MUL1_STEPS = 13;
    localparam int MUL2_STEPS = 13;
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 13;
    localparam int CNT_W      = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SQRT,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

// ===== src/elliptic_region_row_span.sv =====
// Row span of an ellipse inscribed in a bounding box, with a running packed total.
// Bit-serial multipliers, square root and dividers; constants from ers_pkg.
//
//   channel | direction | handshake          | payload
//   s_*     | in        | s_tvalid/s_tready  | s_tdata box and row, s_tuser first_row
//   m_*     | out       | m_tvalid/m_tready  | m_tdata span and totals, m_tuser box_error
//   cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (13 bits kept)
//
// A request passes from acceptance to the result register through four radix-2
// multipliers, a radix-4 multiplier, the square root, a preparation step, two
// restoring dividers and a final step; the square root is the longest step. The input
// opens again only when the result is registered, so one request is handled at a time.
// Reset (rst_n low, asynchronous) sets both field dimensions to 4096 and the total to 0.
// A stalled result holds in the output register; the next request is then held in
// its final cycle until the register frees.
module elliptic_region_row_span
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // box_col, box_row, box_width, box_height, row_index, zero padding
    input  logic [ers_pkg::IN_DATA_W-1:0]        s_tdata,
    // first_row
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // span_first, span_last, span_len, pixel_addr, packed_offset, total_after, padding
    output logic [ers_pkg::OUT_DATA_W-1:0]       m_tdata,
    // box_error
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ers_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ers_pkg::DIM_W-1:0]            cfg_data
);

    ers_pkg::state_t state_reg, state_next;
    logic [ers_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic [12:0] field_width_reg, field_width_next;
    logic [12:0] field_height_reg, field_height_next;
    logic [24:0] total_reg, total_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic [111:0] m_tdata_reg, m_tdata_next;
    logic         m_tuser_reg, m_tuser_next;

    logic [11:0] col_reg, col_next;
    logic [12:0] w_reg, w_next;
    logic [12:0] h_reg, h_next;
    logic        clear_reg, clear_next;
    logic        err_reg, err_next;

    logic [25:0] q_mc_reg, q_mc_next;
    logic [12:0] q_mp_reg, q_mp_next;
    logic [25:0] q_reg, q_next;
    logic [25:0] ww_mc_reg, ww_mc_next;
    logic [12:0] ww_mp_reg, ww_mp_next;
    logic [49:0] ww_reg, ww_next;
    logic [25:0] bs_mc_reg, bs_mc_next;
    logic [12:0] bs_mp_reg, bs_mp_next;
    logic [25:0] base_reg, base_next;
    logic [25:0] rp_mc_reg, rp_mc_next;
    logic [12:0] rp_mp_reg, rp_mp_next;
    logic [25:0] rp_reg, rp_next;

    logic [49:0] prod_reg, prod_next;
    logic [26:0] rem_reg, rem_next;
    logic [24:0] root_reg, root_next;

    logic [14:0] dhi_r_reg, dhi_r_next;
    logic [12:0] dhi_q_reg, dhi_q_next;
    logic [14:0] dlo_r_reg, dlo_r_next;
    logic [12:0] dlo_q_reg, dlo_q_next;
    logic        base_gt_reg, base_gt_next;

    assign s_tready  = (state_reg == ers_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        logic [11:0] in_col;
        logic [11:0] in_row;
        logic [12:0] in_w;
        logic [12:0] in_h;
        logic [11:0] in_ri;
        logic [13:0] b_wide;
        logic [26:0] t_sq;
        logic [26:0] trial;
        logic        sq_ge;
        logic [26:0] nhi;
        logic [26:0] nlo;
        logic [14:0] dvs;
        logic [14:0] t_hi;
        logic [14:0] t_lo;
        logic [12:0] wm1;
        logic [12:0] hi;
        logic [12:0] lo;
        logic        nonempty;
        logic [12:0] len;
        logic [11:0] first;
        logic [11:0] last;
        logic [23:0] addr;
        logic [24:0] total_prev;

        in_col = s_tdata[ers_pkg::IN_COL_LSB +: ers_pkg::COL_W];
        in_row = s_tdata[ers_pkg::IN_ROW_LSB +: ers_pkg::ROW_W];
        in_w   = s_tdata[ers_pkg::IN_W_LSB +: ers_pkg::DIM_W];
        in_h   = s_tdata[ers_pkg::IN_H_LSB +: ers_pkg::DIM_W];
        in_ri  = s_tdata[ers_pkg::IN_RIDX_LSB +: ers_pkg::RIDX_W];
        b_wide = {in_h, 1'b0} - {1'b0, in_ri, 1'b1};

        t_sq  = {rem_reg[24:0], prod_reg[49:48]};
        trial = {root_reg, 2'b01};
        sq_ge = (t_sq >= trial);

        nhi = {1'b0, base_reg} + {2'b00, root_reg};
        nlo = {1'b0, base_reg} + {13'd0, h_reg, 1'b0} - 27'd1 - {2'b00, root_reg};
        dvs = {1'b0, h_reg, 1'b0};
        t_hi = {dhi_r_reg[13:0], dhi_q_reg[12]};
        t_lo = {dlo_r_reg[13:0], dlo_q_reg[12]};

        wm1        = w_reg - 13'd1;
        hi         = (dhi_q_reg > wm1) ? wm1 : dhi_q_reg;
        lo         = base_gt_reg ? dlo_q_reg : 13'd0;
        nonempty   = !err_reg && (w_reg != 13'd0) && (hi >= lo);
        len        = nonempty ? (hi - lo + 13'd1) : 13'd0;
        first      = nonempty ? lo[11:0] : 12'd0;
        last       = nonempty ? hi[11:0] : 12'd0;
        addr       = nonempty ? (rp_reg[23:0] + {12'd0, col_reg} + {12'd0, lo[11:0]}) : 24'd0;
        total_prev = clear_reg ? 25'd0 : total_reg;

        state_next        = state_reg;
        cnt_next          = cnt_reg;
        field_width_next  = field_width_reg;
        field_height_next = field_height_reg;
        total_next        = total_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        col_next          = col_reg;
        w_next            = w_reg;
        h_next            = h_reg;
        clear_next        = clear_reg;
        err_next          = err_reg;
        q_mc_next         = q_mc_reg;
        q_mp_next         = q_mp_reg;
        q_next            = q_reg;
        ww_mc_next        = ww_mc_reg;
        ww_mp_next        = ww_mp_reg;
        ww_next           = ww_reg;
        bs_mc_next        = bs_mc_reg;
        bs_mp_next        = bs_mp_reg;
        base_next         = base_reg;
        rp_mc_next        = rp_mc_reg;
        rp_mp_next        = rp_mp_reg;
        rp_next           = rp_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        dhi_r_next        = dhi_r_reg;
        dhi_q_next        = dhi_q_reg;
        dlo_r_next        = dlo_r_reg;
        dlo_q_next        = dlo_q_reg;
        base_gt_next      = base_gt_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                ers_pkg::CFG_FIELD_WIDTH:  field_width_next  = cfg_data;
                ers_pkg::CFG_FIELD_HEIGHT: field_height_next = cfg_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ers_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    col_next   = in_col;
                    w_next     = in_w;
                    h_next     = in_h;
                    clear_next = s_tuser;
                    err_next   = (({2'b00, in_col} + {1'b0, in_w}) > {1'b0, field_width_reg})
                              || (({2'b00, in_row} + {1'b0, in_h}) > {1'b0, field_height_reg})
                              || ({1'b0, in_ri} >= in_h);
                    // q = (2i+1)(2H-2i-1), W*W, H(W-1) and the row start of the field.
                    q_mc_next  = {13'd0, in_ri, 1'b1};
                    q_mp_next  = b_wide[12:0];
                    q_next     = 26'd0;
                    ww_mc_next = {13'd0, in_w};
                    ww_mp_next = in_w;
                    ww_next    = 50'd0;
                    bs_mc_next = {13'd0, in_h};
                    bs_mp_next = in_w - 13'd1;
                    base_next  = 26'd0;
                    rp_mc_next = {13'd0, {1'b0, in_row} + {1'b0, in_ri}};
                    rp_mp_next = field_width_reg;
                    rp_next    = 26'd0;
                    prod_next  = 50'd0;
                    rem_next   = 27'd0;
                    root_next  = 25'd0;
                    cnt_next   = '0;
                    state_next = ers_pkg::ST_MUL1;
                end
            end

            ers_pkg::ST_MUL1:
            begin
                q_next     = q_reg + (q_mp_reg[0] ? q_mc_reg : 26'd0);
                ww_next    = ww_reg + (ww_mp_reg[0] ? {24'd0, ww_mc_reg} : 50'd0);
                base_next  = base_reg + (bs_mp_reg[0] ? bs_mc_reg : 26'd0);
                rp_next    = rp_reg + (rp_mp_reg[0] ? rp_mc_reg : 26'd0);
                q_mc_next  = {q_mc_reg[24:0], 1'b0};
                ww_mc_next = {ww_mc_reg[24:0], 1'b0};
                bs_mc_next = {bs_mc_reg[24:0], 1'b0};
                rp_mc_next = {rp_mc_reg[24:0], 1'b0};
                q_mp_next  = {1'b0, q_mp_reg[12:1]};
                ww_mp_next = {1'b0, ww_mp_reg[12:1]};
                bs_mp_next = {1'b0, bs_mp_reg[12:1]};
                rp_mp_next = {1'b0, rp_mp_reg[12:1]};
                cnt_next   = cnt_reg + ers_pkg::CNT_W'(1);
                if (cnt_reg == ers_pkg::CNT_W'(ers_pkg::MUL1_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ers_pkg::ST_MUL2;
                end
            end

            ers_pkg::ST_MUL2:
            begin
                // Two multiplier bits of q per cycle against the shifting W*W.
                prod_next = prod_reg + (q_reg[0] ? ww_reg : 50'd0)
                                     + (q_reg[1] ? {ww_reg[48:0], 1'b0} : 50'd0);
                ww_next   = {ww_reg[47:0], 2'b00};
                q_next    = {2'b00, q_reg[25:2]};
                cnt_next  = cnt_reg + ers_pkg::CNT_W'(1);
                if (cnt_reg == ers_pkg::CNT_W'(ers_pkg::MUL2_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ers_pkg::ST_SQRT;
                end
            end

            ers_pkg::ST_SQRT:
            begin
                // One root bit per cycle from the top two bits of the radicand.
                prod_next = {prod_reg[47:0], 2'b00};
                rem_next  = sq_ge ? (t_sq - trial) : t_sq;
                root_next = {root_reg[23:0], sq_ge};
                cnt_next  = cnt_reg + ers_pkg::CNT_W'(1);
                if (cnt_reg == ers_pkg::CNT_W'(ers_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ers_pkg::ST_PREP;
                end
            end

            ers_pkg::ST_PREP:
            begin
                // The lower bound is a ceiling, so d-1 is added before the floor division.
                base_gt_next = (base_reg > {1'b0, root_reg});
                dhi_r_next   = {2'b00, nhi[25:13]};
                dhi_q_next   = nhi[12:0];
                dlo_r_next   = {2'b00, nlo[25:13]};
                dlo_q_next   = nlo[12:0];
                state_next   = ers_pkg::ST_DIV;
            end

            ers_pkg::ST_DIV:
            begin
                dhi_r_next = (t_hi >= dvs) ? (t_hi - dvs) : t_hi;
                dhi_q_next = {dhi_q_reg[11:0], (t_hi >= dvs)};
                dlo_r_next = (t_lo >= dvs) ? (t_lo - dvs) : t_lo;
                dlo_q_next = {dlo_q_reg[11:0], (t_lo >= dvs)};
                cnt_next   = cnt_reg + ers_pkg::CNT_W'(1);
                if (cnt_reg == ers_pkg::CNT_W'(ers_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ers_pkg::ST_FIN;
                end
            end

            ers_pkg::ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    total_next    = total_prev + {12'd0, len};
                    m_tdata_next  = {1'b0, total_prev + {12'd0, len}, total_prev, addr, len,
                                     last, first};
                    m_tuser_next  = err_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ers_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ers_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ers_pkg::ST_IDLE;
            cnt_reg          <= '0;
            field_width_reg  <= 13'(ers_pkg::MAX_DIM);
            field_height_reg <= 13'(ers_pkg::MAX_DIM);
            total_reg        <= 25'd0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            field_width_reg  <= field_width_next;
            field_height_reg <= field_height_next;
            total_reg        <= total_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        col_reg     <= col_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        clear_reg   <= clear_next;
        err_reg     <= err_next;
        q_mc_reg    <= q_mc_next;
        q_mp_reg    <= q_mp_next;
        q_reg       <= q_next;
        ww_mc_reg   <= ww_mc_next;
        ww_mp_reg   <= ww_mp_next;
        ww_reg      <= ww_next;
        bs_mc_reg   <= bs_mc_next;
        bs_mp_reg   <= bs_mp_next;
        base_reg    <= base_next;
        rp_mc_reg   <= rp_mc_next;
        rp_mp_reg   <= rp_mp_next;
        rp_reg      <= rp_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        dhi_r_reg   <= dhi_r_next;
        dhi_q_reg   <= dhi_q_next;
        dlo_r_reg   <= dlo_r_next;
        dlo_q_reg   <= dlo_q_next;
        base_gt_reg <= base_gt_next;
    end

endmodule

// ===== src/ers_checker.sv =====
// Port-level checks for elliptic_region_row_span, attached by the bind below.
// Depends on ers_pkg for the field layout of the result data.
module ers_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [ers_pkg::IN_DATA_W-1:0]        s_tdata,
    input logic                                 s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [ers_pkg::OUT_DATA_W-1:0]       m_tdata,
    input logic                                 m_tuser,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [ers_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [ers_pkg::DIM_W-1:0]            cfg_data
);

    logic [ers_pkg::LEN_W-1:0]   out_len;
    logic [ers_pkg::ADDR_W-1:0]  out_addr;
    logic [ers_pkg::TOTAL_W-1:0] out_ofs;
    logic [ers_pkg::TOTAL_W-1:0] out_after;

    assign out_len   = m_tdata[ers_pkg::OUT_LEN_LSB +: ers_pkg::LEN_W];
    assign out_addr  = m_tdata[ers_pkg::OUT_ADDR_LSB +: ers_pkg::ADDR_W];
    assign out_ofs   = m_tdata[ers_pkg::OUT_OFS_LSB +: ers_pkg::TOTAL_W];
    assign out_after = m_tdata[ers_pkg::OUT_AFTER_LSB +: ers_pkg::TOTAL_W];

    // A stalled result keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One request at a time: the input side closes after each request.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // The total after a row is the offset plus the span length.
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_after == ers_pkg::TOTAL_W'(out_ofs + ers_pkg::TOTAL_W'(out_len)))
        else $error("running total inconsistent");

    // A box error always gives an empty span.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> out_len == '0)
        else $error("non-empty span with box error");

    // An empty span reports a zero address and zero column bounds.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_len == '0 |->
            out_addr == '0 && m_tdata[ers_pkg::OUT_FIRST_LSB +: ers_pkg::SPAN_W] == '0
            && m_tdata[ers_pkg::OUT_LAST_LSB +: ers_pkg::SPAN_W] == '0)
        else $error("empty span with non-zero fields");

endmodule

bind elliptic_region_row_span ers_checker u_ers_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for elliptic_region_row_span: random rows and boxes go in, and
// the span, address and packed totals that come back are compared with a predictor here.
// Depends on ers_pkg and the elliptic_region_row_span RTL only.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ers_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_CAP = 50;

    typedef struct {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [DIM_W-1:0]  bw;
        logic [DIM_W-1:0]  bh;
        logic [RIDX_W-1:0] ridx;
        logic              first_row;
    } row_req_t;

    typedef struct {
        logic [SPAN_W-1:0]  span_first;
        logic [SPAN_W-1:0]  span_last;
        logic [LEN_W-1:0]   span_len;
        logic [ADDR_W-1:0]  addr;
        logic [TOTAL_W-1:0] offset;
        logic [TOTAL_W-1:0] after;
        logic               box_err;
    } row_span_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    // Predictor state: field size and the running packed pixel count.
    logic [DIM_W-1:0]   fld_w;
    logic [DIM_W-1:0]   fld_h;
    logic [TOTAL_W-1:0] packed_total;

    row_span_t expected_spans[$];
    row_span_t got_span;
    row_span_t want_span;

    bit idle_on = 1'b1;
    int span_faults = 0;
    int rows_sent = 0;
    int spans_seen = 0;
    int reg_writes = 0;
    int error_rows = 0;
    int empty_rows = 0;
    int quiet_cycles = 0;

    elliptic_region_row_span dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Quotient rounded towards minus infinity; the divisor is always positive.
    function automatic longint floor_quot(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic row_span_t predict_span(input row_req_t r);
        row_span_t o;
        longint c, rw, bw, bh, ri, fw, fh;
        longint q, root, base, den, lo, hi;
        c  = r.col;
        rw = r.row;
        bw = r.bw;
        bh = r.bh;
        ri = r.ridx;
        fw = fld_w;
        fh = fld_h;
        o = '{default: '0};
        // The clear happens even for a request that ends in an error.
        if (r.first_row)
            packed_total = '0;
        o.offset = packed_total;
        o.box_err = (c + bw > fw) || (rw + bh > fh) || (ri >= bh);
        if (!o.box_err && bw > 0)
        begin
            q    = (2 * ri + 1) * (2 * bh - 2 * ri - 1);
            root = root_floor(bw * bw * q);
            base = bh * (bw - 1);
            den  = 2 * bh;
            lo   = -floor_quot(root - base, den);
            hi   = floor_quot(base + root, den);
            if (lo < 0)
                lo = 0;
            if (hi > bw - 1)
                hi = bw - 1;
            if (hi >= lo)
            begin
                o.span_first = SPAN_W'(lo);
                o.span_last  = SPAN_W'(hi);
                o.span_len   = LEN_W'(hi - lo + 1);
                o.addr       = ADDR_W'((rw + ri) * fw + c + lo);
            end
        end
        packed_total = TOTAL_W'(packed_total + TOTAL_W'(o.span_len));
        o.after = packed_total;
        if (o.box_err)
            error_rows++;
        if (o.span_len == 0)
            empty_rows++;
        return o;
    endfunction

    function automatic row_req_t mk_row(input int col, input int row, input int bw,
                                        input int bh, input int ridx, input bit clr);
        row_req_t r;
        r.col       = COL_W'(col);
        r.row       = ROW_W'(row);
        r.bw        = DIM_W'(bw);
        r.bh        = DIM_W'(bh);
        r.ridx      = RIDX_W'(ridx);
        r.first_row = clr;
        return r;
    endfunction

    // Box dimension at most lim, mostly small, sometimes the full extent.
    function automatic int draw_dim(input int lim, input int lo);
        int top;
        case ($urandom_range(0, 3))
            0: top = (lim < 8) ? lim : 8;
            1: top = (lim < 64) ? lim : 64;
            2: top = lim;
            default: return lim;
        endcase
        return $urandom_range(lo, top);
    endfunction

    task automatic send_row(input row_req_t r);
        logic [IN_DATA_W-1:0] word;
        int gap;
        word = '0;
        word[IN_COL_LSB +: COL_W]   = r.col;
        word[IN_ROW_LSB +: ROW_W]   = r.row;
        word[IN_W_LSB +: DIM_W]     = r.bw;
        word[IN_H_LSB +: DIM_W]     = r.bh;
        word[IN_RIDX_LSB +: RIDX_W] = r.ridx;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= word;
        s_tuser  <= r.first_row;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_spans.push_back(predict_span(r));
        rows_sent++;
    endtask

    // Drop the request line and wait until every span has come back.
    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val[DIM_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_FIELD_WIDTH)
            fld_w = val[DIM_W-1:0];
        else
            fld_h = val[DIM_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_field(input int fw, input int fh);
        settle_idle();
        write_reg(CFG_FIELD_WIDTH, fw);
        write_reg(CFG_FIELD_HEIGHT, fh);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            span_faults++;
            if (span_faults <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // Receiver side: a fresh stall is drawn for every result.
    initial
    begin : ready_gen
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 18) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            spans_seen++;
            got_span.span_first = m_tdata[OUT_FIRST_LSB +: SPAN_W];
            got_span.span_last  = m_tdata[OUT_LAST_LSB +: SPAN_W];
            got_span.span_len   = m_tdata[OUT_LEN_LSB +: LEN_W];
            got_span.addr       = m_tdata[OUT_ADDR_LSB +: ADDR_W];
            got_span.offset     = m_tdata[OUT_OFS_LSB +: TOTAL_W];
            got_span.after      = m_tdata[OUT_AFTER_LSB +: TOTAL_W];
            got_span.box_err    = m_tuser;
            if (expected_spans.size() == 0)
            begin
                span_faults++;
                $display("%0t ns: span returned with no request outstanding", $time);
            end
            else
            begin
                want_span = expected_spans.pop_front();
                check_field("span_first", want_span.span_first, got_span.span_first);
                check_field("span_last", want_span.span_last, got_span.span_last);
                check_field("span_len", want_span.span_len, got_span.span_len);
                check_field("pixel_addr", want_span.addr, got_span.addr);
                check_field("packed_offset", want_span.offset, got_span.offset);
                check_field("total_after", want_span.after, got_span.after);
                check_field("box_error", want_span.box_err, got_span.box_err);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles, %0d spans outstanding",
                     $time, quiet_cycles, expected_spans.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_directed_spans();
        idle_on = 1'b1;
        send_row(mk_row(0, 0, 4096, 4096, 0, 1));       // thin top row of the largest box
        send_row(mk_row(0, 0, 4096, 4096, 2047, 0));    // widest row
        send_row(mk_row(0, 0, 4096, 4096, 4095, 0));    // bottom row
        send_row(mk_row(0, 0, 4096, 1, 0, 0));
        send_row(mk_row(0, 0, 1, 1, 0, 0));
        send_row(mk_row(4095, 4095, 1, 1, 0, 0));       // highest field address
        send_row(mk_row(100, 200, 0, 10, 3, 0));        // zero width, no error
        send_row(mk_row(7, 9, 3, 200, 0, 0));           // narrow box, thin rows
        send_row(mk_row(7, 9, 3, 200, 199, 0));
        send_row(mk_row(7, 9, 2, 2, 0, 0));
        send_row(mk_row(7, 9, 2, 2, 1, 0));
        send_row(mk_row(4095, 0, 2, 4, 1, 1));          // past the right edge, with a clear
        send_row(mk_row(0, 4000, 8, 200, 5, 0));        // past the bottom edge
        send_row(mk_row(10, 10, 20, 5, 5, 0));          // row index equal to the height
        send_row(mk_row(10, 10, 20, 0, 0, 0));          // zero height
        send_row(mk_row(0, 0, 4096, 100, 4095, 0));
        send_row(mk_row(1, 0, 4096, 4096, 2047, 0));
        send_row(mk_row(0, 1, 4096, 4096, 2047, 0));
        send_row(mk_row(2048, 1024, 33, 17, 8, 1));     // clear in the middle of a run
        send_row(mk_row(2048, 1024, 33, 17, 9, 0));
        send_row(mk_row(2048, 1024, 33, 17, 16, 0));
    endtask

    task automatic test_field_registers();
        idle_on = 1'b1;
        set_field(1, 1);
        send_row(mk_row(0, 0, 1, 1, 0, 1));
        send_row(mk_row(0, 0, 2, 1, 0, 0));
        send_row(mk_row(0, 1, 1, 1, 0, 0));
        send_row(mk_row(0, 0, 0, 1, 0, 0));
        set_field(MAX_DIM, 1);
        send_row(mk_row(0, 0, 4096, 1, 0, 0));
        send_row(mk_row(0, 0, 4096, 2, 0, 0));
        set_field(1, MAX_DIM);
        send_row(mk_row(0, 0, 1, 4096, 2048, 0));
        send_row(mk_row(0, 4095, 1, 1, 0, 0));
        set_field(MAX_DIM, MAX_DIM);
    endtask

    // Full-width rows back to back, so that the total grows by nearly 4096 per row.
    task automatic test_full_rows();
        idle_on = 1'b0;
        send_row(mk_row(0, 0, 4096, 4096, 2047, 1));
        for (int k = 0; k < 20; k++)
            send_row(mk_row(0, 0, 4096, 4096, 2047 - (k % 3), 0));
        settle_idle();
    endtask

    task automatic test_random_rows();
        int ph, fw, fh, quota, sent, kind;
        int bw, bh, col, row, top, cnt, k;
        bit clr;
        for (ph = 0; ph < 8; ph++)
        begin
            quota = 190;
            case (ph)
                0: begin fw = MAX_DIM; fh = MAX_DIM; end
                1: begin fw = $urandom_range(1, MAX_DIM); fh = $urandom_range(1, MAX_DIM); end
                2: begin fw = MAX_DIM; fh = 1; end
                3: begin fw = 1; fh = MAX_DIM; end
                4: begin fw = $urandom_range(1, 64); fh = $urandom_range(1, 64); end
                5: begin fw = $urandom_range(1, 300); fh = $urandom_range(1, MAX_DIM); end
                6: begin fw = 1; fh = 1; quota = 40; end
                default: begin fw = MAX_DIM; fh = MAX_DIM; end
            endcase
            set_field(fw, fh);
            sent = 0;
            while (sent < quota)
            begin
                kind = $urandom_range(0, 9);
                idle_on = ($urandom_range(0, 3) != 0);
                if (kind <= 5)
                begin
                    // A run of consecutive rows of one box, in most runs cleared at its first row.
                    bw  = draw_dim(fw, 0);
                    bh  = draw_dim(fh, 1);
                    col = $urandom_range(0, (fw - bw < 4095) ? fw - bw : 4095);
                    row = $urandom_range(0, (fh - bh < 4095) ? fh - bh : 4095);
                    if (bh <= 24)
                    begin
                        top = 0;
                        cnt = bh;
                    end
                    else
                    begin
                        cnt = $urandom_range(1, 12);
                        top = $urandom_range(0, bh - cnt);
                    end
                    clr = ($urandom_range(0, 9) != 0);
                    for (k = 0; k < cnt; k++)
                        send_row(mk_row(col, row, bw, bh, top + k, clr && k == 0));
                    sent += cnt;
                end
                else if (kind <= 7)
                begin
                    bw  = draw_dim(fw, 0);
                    bh  = draw_dim(fh, 1);
                    col = $urandom_range(0, (fw - bw < 4095) ? fw - bw : 4095);
                    row = $urandom_range(0, (fh - bh < 4095) ? fh - bh : 4095);
                    send_row(mk_row(col, row, bw, bh, $urandom_range(0, bh - 1),
                                    1'($urandom_range(0, 1))));
                    sent++;
                end
                else
                begin
                    send_row(mk_row($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 4096), $urandom_range(0, 4096),
                                    $urandom_range(0, 4095), 1'($urandom_range(0, 1))));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FIELD_WIDTH;
        cfg_data  = '0;
        fld_w        = MAX_DIM;
        fld_h        = MAX_DIM;
        packed_total = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_spans();
        test_field_registers();
        test_full_rows();
        test_random_rows();

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d rows (%0d out of bounds, %0d with empty spans), %0d register writes,",
                 rows_sent, error_rows, empty_rows, reg_writes);
        $display("including a run of full-width rows; %0d spans came back and were compared.",
                 spans_seen);
        if (span_faults == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
